/* rtl/mdu_pkg.sv */
// Package for the multiply/divide unit: operation codes and the mode width constant.
// No dependencies; mdu_front, mdu_back and the bench use it by scoped names.
package mdu_pkg;

    localparam int unsigned ModeWidth = 2;

    typedef enum logic [ModeWidth-1:0] {
        MODE_MULU = 2'd0,
        MODE_MULS = 2'd1,
        MODE_DIVU = 2'd2,
        MODE_DIVS = 2'd3
    } t_mode;

endpackage

/* rtl/mdu_stream_if.sv */
// Valid/ready channel interface carrying a payload of a parameterized width.
// Depends on nothing; the unit's top level uses it for its input and output channels.
interface mdu_stream_if #(
    parameter int unsigned PAYLOAD_WIDTH = 34
);
    logic                     valid;
    logic                     ready;
    logic [PAYLOAD_WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mdu_front.sv */
// Front end: accepts operations, classifies them and prepares the magnitudes for the back end.
// Depends on mdu_pkg.
module mdu_front #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_mode,
    input  logic [DATA_WIDTH-1:0]   i_operand_a,
    input  logic [DATA_WIDTH-1:0]   i_operand_b,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_mode,
    output logic [DATA_WIDTH-1:0]   o_mag_a,
    output logic [DATA_WIDTH-1:0]   o_mag_b,
    output logic                    o_neg_q,
    output logic                    o_neg_r,
    output logic                    o_zero,
    output logic [DATA_WIDTH-1:0]   o_raw_a
);
    logic                  r_valid;
    logic [1:0]            r_mode;
    logic [DATA_WIDTH-1:0] r_mag_a, r_mag_b, r_raw_a;
    logic                  r_neg_q, r_neg_r, r_zero;
    logic                  a_neg, b_neg, take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign a_neg   = i_operand_a[DATA_WIDTH-1];
    assign b_neg   = i_operand_b[DATA_WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (take) begin
            r_mode  <= i_mode;
            r_raw_a <= i_operand_a;
            r_zero  <= (i_operand_b == '0);
            if (i_mode == mdu_pkg::MODE_DIVS) begin
                r_mag_a <= a_neg ? (~i_operand_a + 1'b1) : i_operand_a;
                r_mag_b <= b_neg ? (~i_operand_b + 1'b1) : i_operand_b;
                r_neg_q <= a_neg ^ b_neg;
                r_neg_r <= a_neg;
            end else begin
                r_mag_a <= i_operand_a;
                r_mag_b <= i_operand_b;
                r_neg_q <= 1'b0;
                r_neg_r <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_mode  = r_mode;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;
    assign o_neg_q = r_neg_q;
    assign o_neg_r = r_neg_r;
    assign o_zero  = r_zero;
    assign o_raw_a = r_raw_a;
endmodule

/* rtl/mdu_back.sv */
// Back end: pipelined multiplier and divider with one quotient bit per stage, plus output register.
// Depends on mdu_pkg.
module mdu_back #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_mode,
    input  logic [DATA_WIDTH-1:0]   i_mag_a,
    input  logic [DATA_WIDTH-1:0]   i_mag_b,
    input  logic                    i_neg_q,
    input  logic                    i_neg_r,
    input  logic                    i_zero,
    input  logic [DATA_WIDTH-1:0]   i_raw_a,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DATA_WIDTH-1:0]   o_result_low,
    output logic [DATA_WIDTH-1:0]   o_result_high,
    output logic                    o_div_by_zero
);
    localparam int unsigned W = DATA_WIDTH;
    localparam int unsigned S = DATA_WIDTH + 1;

    logic           r_v    [S];
    logic [1:0]     r_md   [S];
    logic [W-1:0]   r_rem  [S];
    logic [W-1:0]   r_quo  [S];
    logic [W-1:0]   r_div  [S];
    logic [W-1:0]   r_ra   [S];
    logic           r_nq   [S];
    logic           r_nr   [S];
    logic           r_z    [S];
    logic [2*W-1:0] r_prod [S];

    logic           advance;
    logic           r_ov;
    logic [W-1:0]   r_lo, r_hi;
    logic           r_dz;

    assign advance = !r_ov || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (advance) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < S; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[S-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_md[0]  <= i_mode;
            r_rem[0] <= '0;
            r_quo[0] <= i_mag_a;
            r_div[0] <= i_mag_b;
            r_ra[0]  <= i_raw_a;
            r_nq[0]  <= i_neg_q;
            r_nr[0]  <= i_neg_r;
            r_z[0]   <= i_zero;
            if (i_mode == mdu_pkg::MODE_MULS) begin
                r_prod[0] <= $signed({{W{i_mag_a[W-1]}}, i_mag_a})
                           * $signed({{W{i_mag_b[W-1]}}, i_mag_b});
            end else begin
                r_prod[0] <= {{W{1'b0}}, i_mag_a} * {{W{1'b0}}, i_mag_b};
            end
            for (int k = 1; k < S; k++) begin
                logic [W:0] t;
                t = {r_rem[k-1], r_quo[k-1][W-1]} - {1'b0, r_div[k-1]};
                r_md[k]   <= r_md[k-1];
                r_div[k]  <= r_div[k-1];
                r_ra[k]   <= r_ra[k-1];
                r_nq[k]   <= r_nq[k-1];
                r_nr[k]   <= r_nr[k-1];
                r_z[k]    <= r_z[k-1];
                r_prod[k] <= r_prod[k-1];
                if (!t[W]) begin
                    r_rem[k] <= t[W-1:0];
                    r_quo[k] <= {r_quo[k-1][W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k-1][W-2:0], r_quo[k-1][W-1]};
                    r_quo[k] <= {r_quo[k-1][W-2:0], 1'b0};
                end
            end
            if (r_md[S-1] == mdu_pkg::MODE_MULU || r_md[S-1] == mdu_pkg::MODE_MULS) begin
                r_lo <= r_prod[S-1][W-1:0];
                r_hi <= r_prod[S-1][2*W-1:W];
                r_dz <= 1'b0;
            end else if (r_z[S-1]) begin
                r_lo <= '1;
                r_hi <= r_ra[S-1];
                r_dz <= 1'b1;
            end else begin
                r_lo <= r_nq[S-1] ? (~r_quo[S-1] + 1'b1) : r_quo[S-1];
                r_hi <= r_nr[S-1] ? (~r_rem[S-1] + 1'b1) : r_rem[S-1];
                r_dz <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_result_low  = r_lo;
    assign o_result_high = r_hi;
    assign o_div_by_zero = r_dz;

`ifndef SYNTHESIS
    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_dz |-> r_lo == '1) else $error("dz check");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_lo) && $stable(r_dz)) else $error("stall lost");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_v[S-1] |=> r_ov) else $error("result dropped");
`endif
endmodule

/* rtl/mul_div_unit_16bit.sv */
// Multiply/divide unit top level: front end, back end and the stream interfaces.
// Depends on mdu_pkg, mdu_stream_if, mdu_front and mdu_back.
//
// The input channel carries mode, operand_a and operand_b; the output channel carries
// result_low, result_high and div_by_zero. One transfer in gives one transfer out.
// Multiplies run through a registered product; divides run through a restoring divider
// with one quotient bit per stage, DATA_WIDTH stages. An operation passes the front
// register, the first back-end stage, the divider stages and the output register.
// Throughput is one operation per cycle while the output is taken.
// Reset clears all valid flags; no item is in flight afterwards.
// When the receiver stalls, the whole pipeline holds and the input deasserts ready
// once the front register is full; results are never lost or repeated.
// Signed divide truncates toward zero; a zero divisor gives an all-ones quotient,
// the dividend as remainder and the div_by_zero flag.
module mul_div_unit_16bit #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mdu_stream_if.sink   in_ch,
    mdu_stream_if.source out_ch
);
    logic                  f_valid, b_ready;
    logic [1:0]            f_mode;
    logic [DATA_WIDTH-1:0] f_a, f_b, f_raw;
    logic                  f_nq, f_nr, f_z;

    mdu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_mode(in_ch.payload[2*DATA_WIDTH+1:2*DATA_WIDTH]),
        .i_operand_a(in_ch.payload[2*DATA_WIDTH-1:DATA_WIDTH]),
        .i_operand_b(in_ch.payload[DATA_WIDTH-1:0]),
        .o_valid(f_valid), .i_ready(b_ready), .o_mode(f_mode),
        .o_mag_a(f_a), .o_mag_b(f_b), .o_neg_q(f_nq), .o_neg_r(f_nr),
        .o_zero(f_z), .o_raw_a(f_raw)
    );

    mdu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(b_ready), .i_mode(f_mode),
        .i_mag_a(f_a), .i_mag_b(f_b), .i_neg_q(f_nq), .i_neg_r(f_nr),
        .i_zero(f_z), .i_raw_a(f_raw),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_result_low(out_ch.payload[DATA_WIDTH-1:0]),
        .o_result_high(out_ch.payload[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_div_by_zero(out_ch.payload[2*DATA_WIDTH])
    );
endmodule

/* bench/mdu_checker.sv */
// Checker for the multiply/divide unit: watches both channels, predicts each result and
// compares it field by field. Depends on mdu_pkg for the operation codes.
module mdu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [33:0] i_in_payload,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [32:0] i_out_payload,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_divs_by_zero,
    output int          o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        div_by_zero;
        logic [15:0] result_high;
        logic [15:0] result_low;
    } t_mdu_result;

    t_mdu_result expected_results[$];

    function automatic t_mdu_result compute_mdu(mdu_pkg::t_mode mode, logic [15:0] a,
                                                logic [15:0] b);
        t_mdu_result r;
        logic [31:0] prod;
        logic [15:0] ma;
        logic [15:0] mb;
        logic [15:0] q;
        logic [15:0] rem;
        r = '0;
        case (mode)
            mdu_pkg::MODE_MULU: begin
                prod = {16'd0, a} * {16'd0, b};
                {r.result_high, r.result_low} = prod;
            end
            mdu_pkg::MODE_MULS: begin
                prod = $signed({{16{a[15]}}, a}) * $signed({{16{b[15]}}, b});
                {r.result_high, r.result_low} = prod;
            end
            default: begin
                if (b == 16'd0) begin
                    r.result_low  = 16'hFFFF;
                    r.result_high = a;
                    r.div_by_zero = 1'b1;
                end else if (mode == mdu_pkg::MODE_DIVU) begin
                    r.result_low  = a / b;
                    r.result_high = a % b;
                end else begin
                    ma  = a[15] ? 16'd0 - a : a;
                    mb  = b[15] ? 16'd0 - b : b;
                    q   = ma / mb;
                    rem = ma % mb;
                    r.result_low  = (a[15] != b[15]) ? 16'd0 - q : q;
                    r.result_high = a[15] ? 16'd0 - rem : rem;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_divs_by_zero = 0;
        o_results_seen = 0;
    end

    always @(posedge i_clk) begin
        t_mdu_result got;
        t_mdu_result want;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            expected_results.push_back(compute_mdu(mdu_pkg::t_mode'(i_in_payload[33:32]),
                                                   i_in_payload[31:16], i_in_payload[15:0]));
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got = i_out_payload;
            o_results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, low word", got.result_low, 16'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.result_low !== want.result_low)
                    report_mismatch("result_low", got.result_low, want.result_low);
                if (got.result_high !== want.result_high)
                    report_mismatch("result_high", got.result_high, want.result_high);
                if (got.div_by_zero !== want.div_by_zero)
                    report_mismatch("div_by_zero", {15'd0, got.div_by_zero},
                                    {15'd0, want.div_by_zero});
                if (want.div_by_zero)
                    o_divs_by_zero++;
            end
        end
        o_pending = expected_results.size();
    end
endmodule

/* bench/mul_div_unit_16bit_tb.sv */
// Top of the multiply/divide unit testbench: clock, reset, directed and random operations,
// random stalls on both channels and the verdict. Depends on mdu_pkg, mdu_stream_if,
// mdu_checker and the unit itself.
module mul_div_unit_16bit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomOps = 1200;
    localparam int IdleLimit = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   divs_by_zero;
    int   results_seen;
    int   idle_cycles = 0;
    int   ops_sent = 0;
    int   stall_left = 0;
    bit   timed_out = 1'b0;

    mdu_stream_if #(.PAYLOAD_WIDTH(34)) in_ch ();
    mdu_stream_if #(.PAYLOAD_WIDTH(33)) out_ch ();

    mul_div_unit_16bit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mdu_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_payload  (in_ch.payload),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_payload (out_ch.payload),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_divs_by_zero(divs_by_zero),
        .o_results_seen(results_seen)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'd1;
            5: return 16'(($urandom_range(0, 1) ? 16'hFFF0 : 16'h0000) | $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_op(mdu_pkg::t_mode mode, logic [15:0] a, logic [15:0] b);
        int gap;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= {mode, a, b};
        do @(posedge i_clk); while (!in_ch.ready);
        ops_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer for %0d cycles", IdleLimit);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        mdu_pkg::t_mode all_modes[4];
        all_modes = '{mdu_pkg::MODE_MULU, mdu_pkg::MODE_MULS, mdu_pkg::MODE_DIVU,
                      mdu_pkg::MODE_DIVS};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (all_modes[m]) begin
            send_op(all_modes[m], 16'hFFFF, 16'hFFFF);
            send_op(all_modes[m], 16'h8000, 16'h8000);
            send_op(all_modes[m], 16'h1234, 16'h0000);
            send_op(all_modes[m], 16'h8000, 16'hFFFF);
        end
        send_op(mdu_pkg::MODE_DIVS, 16'h8000, 16'h0000);
        send_op(mdu_pkg::MODE_DIVS, 16'hFFF9, 16'h0002);
        send_op(mdu_pkg::MODE_DIVS, 16'h0007, 16'hFFFE);
        send_op(mdu_pkg::MODE_DIVS, 16'hFFF9, 16'hFFFE);
        send_op(mdu_pkg::MODE_DIVU, 16'h0000, 16'h0000);
        send_op(mdu_pkg::MODE_MULS, 16'h7FFF, 16'h8000);

        repeat (RandomOps)
            send_op(mdu_pkg::t_mode'($urandom_range(0, 3)), pick_operand(), pick_operand());
        in_ch.valid <= 1'b0;

        while (results_seen < ops_sent) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("ran %0d operations over all four modes, %0d results checked",
                 ops_sent, results_seen);
        $display("%0d divides by zero seen, %0d mismatches", divs_by_zero, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* filelist.f */
rtl/mdu_pkg.sv
rtl/mdu_stream_if.sv
rtl/mdu_front.sv
rtl/mdu_back.sv
rtl/mul_div_unit_16bit.sv
bench/mdu_checker.sv
bench/mul_div_unit_16bit_tb.sv
